// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

    // Symbol lookup result: bit 6 set means the byte is not in the alphabet.
    localparam logic [6:0] SymBad = 7'd64;

    localparam logic [7:0] ChPad = 8'h3D;  // '='
    localparam logic [7:0] ChSp  = 8'h20;
    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChVt  = 8'h0B;
    localparam logic [7:0] ChFf  = 8'h0C;
    localparam logic [7:0] ChCr  = 8'h0D;

    // Status codes reported on the last item of a message.
    localparam logic [2:0] STATUS_OK    = 3'd0;
    localparam logic [2:0] STATUS_BAD   = 3'd1;
    localparam logic [2:0] STATUS_LONE  = 3'd2;
    localparam logic [2:0] STATUS_ROOM  = 3'd3;
    localparam logic [2:0] STATUS_EMPTY = 3'd4;

    localparam int QueueDepth = 4;

    // One decoded job: up to three result items produced by one input item.
    typedef struct packed {
        logic [2:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final item of this job
        logic            has_data;  // 0: a single status-only item
        logic [15:0]     base_len;  // byte count before this job
        logic            last;      // job closes the message
        logic [2:0]      status;
    } job_t;

    function automatic logic [6:0] sym_value(input logic [7:0] c);
        logic [6:0] v;
        v = SymBad;
        if (c >= 8'h41 && c <= 8'h5A)
            v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39)
            v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            v = 7'd62;
        else if (c == 8'h2F)
            v = 7'd63;
        return v;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == ChSp) || (c == ChTab) || (c == ChLf) || (c == ChVt)
            || (c == ChFf) || (c == ChCr);
    endfunction

endpackage

// ----- hdl/b64d_front.sv -----
module b64d_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  logic               accept,
    input  logic [7:0]         in_byte,
    input  logic               eom,
    output logic               job_push,
    output b64d_pkg::job_t     job
);

    logic [15:0]      cap_reg;
    logic [2:0][5:0]  held_reg, held_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             pad_reg, pad_next;
    logic [2:0]       err_reg, err_next;
    logic [15:0]      bc_reg, bc_next;

    logic [6:0]       sym;
    logic [16:0]      diff;
    logic             fits, room1, room2, room3;
    logic [1:0]       nbytes;
    logic [15:0]      bc_after;

    assign sym   = b64d_pkg::sym_value(in_byte);
    assign diff  = {1'b0, cap_reg} - {1'b0, bc_reg};
    assign fits  = ~diff[16];
    assign room1 = fits && (diff[15:0] >= 16'd1);
    assign room2 = fits && (diff[15:0] >= 16'd2);
    assign room3 = fits && (diff[15:0] >= 16'd3);

    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        err_next  = err_reg;
        nbytes    = 2'd0;
        job       = '0;
        job.base_len = bc_reg;

        // symbol stage
        if (err_reg == b64d_pkg::STATUS_OK && !pad_reg && !b64d_pkg::is_ws(in_byte))
        begin
            if (in_byte == b64d_pkg::ChPad)
                pad_next = 1'b1;
            else if (sym[6])
                err_next = b64d_pkg::STATUS_BAD;
            else if (cnt_reg != 2'd3)
            begin
                held_next[cnt_reg] = sym[5:0];
                cnt_next = cnt_reg + 2'd1;
            end
            else if (!room3)
                err_next = b64d_pkg::STATUS_ROOM;
            else
            begin
                job.bytes[0] = {held_reg[0], held_reg[1][5:4]};
                job.bytes[1] = {held_reg[1][3:0], held_reg[2][5:2]};
                job.bytes[2] = {held_reg[2][1:0], sym[5:0]};
                nbytes   = 2'd3;
                cnt_next = 2'd0;
            end
        end

        // end of message: flush a partial group
        if (eom && err_next == b64d_pkg::STATUS_OK)
        begin
            if (cnt_next == 2'd1)
                err_next = b64d_pkg::STATUS_LONE;
            else if (cnt_next != 2'd0)
            begin
                if (!room1)
                    err_next = b64d_pkg::STATUS_ROOM;
                else
                begin
                    job.bytes[0] = {held_next[0], held_next[1][5:4]};
                    nbytes = 2'd1;
                    if (cnt_next == 2'd3)
                    begin
                        if (!room2)
                            err_next = b64d_pkg::STATUS_ROOM;
                        else
                        begin
                            job.bytes[1] = {held_next[1][3:0], held_next[2][5:2]};
                            nbytes = 2'd2;
                        end
                    end
                end
            end
        end

        bc_after = bc_reg + 16'(nbytes);
        if (eom && err_next == b64d_pkg::STATUS_OK && bc_after == 16'd0)
            err_next = b64d_pkg::STATUS_EMPTY;

        job.has_data = (nbytes != 2'd0);
        job.last_idx = (nbytes != 2'd0) ? nbytes - 2'd1 : 2'd0;
        job.last     = eom;
        job.status   = eom ? err_next : b64d_pkg::STATUS_OK;
        job_push     = accept && (eom || nbytes != 2'd0);

        bc_next = bc_after;
        if (eom)
        begin
            cnt_next = 2'd0;
            pad_next = 1'b0;
            err_next = b64d_pkg::STATUS_OK;
            bc_next  = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 16'hFFFF;
            cnt_reg <= 2'd0;
            pad_reg <= 1'b0;
            err_reg <= b64d_pkg::STATUS_OK;
            bc_reg  <= 16'd0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (accept)
            begin
                cnt_reg <= cnt_next;
                pad_reg <= pad_next;
                err_reg <= err_next;
                bc_reg  <= bc_next;
            end
        end
    end

    // symbol holding registers, written only while a group fills
    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= held_next;
    end

endmodule

// ----- hdl/b64d_queue.sv -----
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QueueDepth
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64d_pkg::job_t     push_job,
    input  logic               pop,
    output b64d_pkg::job_t     head,
    output logic               full,
    output logic               empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::job_t   mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- hdl/b64d_back.sv -----
module b64d_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  b64d_pkg::job_t     head,
    input  logic               empty,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,
    output logic [3:0]         m_tuser,
    output logic               m_tlast
);

    logic [1:0]   idx_reg;
    logic         valid_reg;
    logic [23:0]  data_reg;
    logic [3:0]   user_reg;
    logic         last_reg;
    logic         load, final_item;
    logic [15:0]  len;

    assign load       = !valid_reg || m_tready;
    assign final_item = (idx_reg == head.last_idx);
    assign pop        = load && !empty && final_item;
    assign len        = head.has_data ? head.base_len + 16'(idx_reg) + 16'd1 : head.base_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty)
                idx_reg <= final_item ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            data_reg <= {len, head.has_data ? head.bytes[idx_reg] : 8'd0};
            last_reg <= head.last && final_item;
            user_reg <= {(head.last && final_item) ? head.status : b64d_pkg::STATUS_OK,
                         head.has_data};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- hdl/base64_stream_decoder.sv -----
// Channel   Dir  Handshake          Contents (lowest bit first)
// s_        in   s_tvalid/s_tready  tdata: in_byte[7:0]; tlast: end_of_message
// m_        out  m_tvalid/m_tready  tdata: out_byte[7:0], decoded_length[23:8];
//                                   tuser: byte_valid[0], status[3:1]; tlast: last
// cfg_      in   cfg_wr_en          cfg_wr_data: output_capacity[15:0]
//
// One input item is taken per cycle while the job queue has room; results leave at one item
// per cycle while m_tready is high and a job waits, from a registered output stage. A full group
// gives three results, so the queue (QUEUE_DEPTH jobs) absorbs bursts; input stalls only when it fills.
// An input item's results pass through the job queue and then the registered output stage.
// Reset (rst_n low, asynchronous) clears the group state, queue and output valid;
// output_capacity returns to 65535.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QueueDepth
)
(
    input  logic         clk,
    input  logic         rst_n,
    // config
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,   // output_capacity
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // [7:0] in_byte
    input  logic         s_tlast,       // end_of_message
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,       // [7:0] out_byte, [23:8] decoded_length
    output logic [3:0]   m_tuser,       // [0] byte_valid, [3:1] status
    output logic         m_tlast        // last
);

    b64d_pkg::job_t  push_job, head;
    logic            accept, job_push, pop, q_full, q_empty;

    // front side is ready whenever a job slot is free
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    b64d_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_byte     (s_tdata),
        .eom         (s_tlast),
        .job_push    (job_push),
        .job         (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64d_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a status-only item always closes its message
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("status-only item without last");

    // status is only reported on the last item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser[3:1] == b64d_pkg::STATUS_OK)
        else $error("nonzero status before last");

    // a data byte always counts itself in the length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[23:8] != 16'd0)
        else $error("data byte with zero length");

    // an empty message reports EMPTY unless an earlier error stood
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && !m_tuser[0] && m_tdata[23:8] == 16'd0 |->
            m_tuser[3:1] != b64d_pkg::STATUS_OK)
        else $error("empty message reported ok");

endmodule
